// ===== design/mpfe_pkg.sv =====
// shared types and constants of the manchester pulse frame encoder
package mpfe_pkg;

    // field widths
    localparam int unsigned STATION_W  = 13;
    localparam int unsigned PAGER_W    = 10;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned FRAME_BITS = STATION_W + PAGER_W + 1;
    localparam int unsigned SYMBOLS    = 2 * FRAME_BITS;
    localparam int unsigned SYM_CNT_W  = $clog2(SYMBOLS);

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = DUR_W;

    // register reset values
    localparam logic [DUR_W-1:0] SHORT_RST = 16'd200;
    localparam logic [DUR_W-1:0] LONG_RST  = 16'd600;
    localparam logic [DUR_W-1:0] GAP_RST   = 16'd6000;
    localparam logic [DUR_W-1:0] TAIL_RST  = 16'd200;
    localparam logic             POL_RST   = 1'b0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT    = 3'd0,
        CFG_LONG     = 3'd1,
        CFG_GAP      = 3'd2,
        CFG_TAIL     = 3'd3,
        CFG_POLARITY = 3'd4
    } t_cfg_idx;

    // input item
    typedef struct packed {
        logic [STATION_W-1:0] station;
        logic [PAGER_W-1:0]   pager;
        logic                 action;
    } t_in_item;

    // result item: one pulse
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
        logic             last;
    } t_out_item;

    // control of the symbol cells
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // frame sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GAP0,
        PH_DATA,
        PH_TAIL,
        PH_GAP1
    } t_phase;

endpackage

// ===== design/mpfe_sym_cell.sv =====
// one symbol cell: loads its half-bit symbol or takes the one from its neighbour
module mpfe_sym_cell (
    input  logic                  i_clk,
    input  mpfe_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_load_bit,
    input  logic                  i_next_bit,
    output logic                  o_bit
);
    import mpfe_pkg::*;

    logic r_bit;
    logic n_bit;

    // load wins over shift, otherwise hold
    always_comb begin
        n_bit = r_bit;
        if (i_ctl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctl.shift) begin
            n_bit = i_next_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

// ===== design/mpfe_sym_chain.sv =====
// row of symbol cells holding the manchester coded frame, head at cell 0
module mpfe_sym_chain (
    input  logic                            i_clk,
    input  mpfe_pkg::t_cell_ctl             i_ctl,
    input  logic [mpfe_pkg::FRAME_BITS-1:0] i_frame,
    input  logic                            i_polarity,
    output logic                            o_head
);
    import mpfe_pkg::*;

    logic [SYMBOLS-1:0] load_bits;
    logic [SYMBOLS-1:0] sym_q;

    // manchester coding: first half is the bit xor polarity, second half its inverse
    always_comb begin
        for (int i = 0; i < FRAME_BITS; i++) begin
            load_bits[2*i]     = i_frame[i] ^ i_polarity;
            load_bits[2*i + 1] = ~(i_frame[i] ^ i_polarity);
        end
    end

    // cells shift towards the head, the far end fills with zero
    for (genvar g = 0; g < SYMBOLS; g++) begin : g_cell
        logic next_bit;
        if (g == SYMBOLS - 1) begin : g_end
            assign next_bit = 1'b0;
        end else begin : g_mid
            assign next_bit = sym_q[g + 1];
        end
        mpfe_sym_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_load_bit (load_bits[g]),
            .i_next_bit (next_bit),
            .o_bit      (sym_q[g])
        );
    end

    assign o_head = sym_q[0];

endmodule

// ===== design/manchester_pulse_frame_encoder_core.sv =====
// Manchester pulse frame encoder: one frame in, 51 pulses out, one pulse per cycle while the
// receiver takes them. From idle, the input transfer first sets the sequencer phase, then the
// opening gap pulse goes into the output register. Data pulses leave the symbol cell row head;
// the next frame is taken in the cycle its predecessor's closing gap is issued.
// Reset: duration registers and polarity go to their defaults, sequencer idle, output empty.
module manchester_pulse_frame_encoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mpfe_pkg::t_in_item             i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mpfe_pkg::t_out_item            o_out_data,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [mpfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mpfe_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mpfe_pkg::*;

    // configuration registers
    logic [DUR_W-1:0] r_short;
    logic [DUR_W-1:0] r_long;
    logic [DUR_W-1:0] r_gap;
    logic [DUR_W-1:0] r_tail;
    logic             r_pol;

    // sequencer and output stage
    t_phase               r_phase;
    t_phase               n_phase;
    logic [SYM_CNT_W-1:0] r_cnt;
    logic [SYM_CNT_W-1:0] n_cnt;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic      adv;
    logic      emit;
    logic      in_ready;
    logic      in_xfer;
    logic      sym_head;
    logic      data_end;
    t_out_item pulse;
    t_cell_ctl cell_ctl;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= SHORT_RST;
            r_long  <= LONG_RST;
            r_gap   <= GAP_RST;
            r_tail  <= TAIL_RST;
            r_pol   <= POL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SHORT:    r_short <= i_cfg_wdata;
                CFG_LONG:     r_long  <= i_cfg_wdata;
                CFG_GAP:      r_gap   <= i_cfg_wdata;
                CFG_TAIL:     r_tail  <= i_cfg_wdata;
                CFG_POLARITY: r_pol   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // output slot free for a new pulse
    assign adv      = !r_out_valid || i_out_ready;
    assign data_end = (r_cnt == SYM_CNT_W'(SYMBOLS - 1));
    assign in_xfer  = i_in_valid && in_ready;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: if (in_xfer) n_phase = PH_GAP0;
            PH_GAP0: if (adv) n_phase = PH_DATA;
            PH_DATA: if (adv && data_end) n_phase = PH_TAIL;
            PH_TAIL: if (adv) n_phase = PH_GAP1;
            PH_GAP1: begin
                if (adv) begin
                    n_phase = in_xfer ? PH_GAP0 : PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // phase outputs: pulse contents, cell control, input ready, next symbol count
    always_comb begin
        pulse          = '0;
        emit           = 1'b0;
        in_ready       = 1'b0;
        cell_ctl.shift = 1'b0;
        n_cnt          = r_cnt;
        case (r_phase)
            PH_IDLE: begin
                in_ready = 1'b1;
            end
            PH_GAP0: begin
                emit           = adv;
                pulse.level    = 1'b0;
                pulse.duration = r_gap;
                if (adv) n_cnt = '0;
            end
            PH_DATA: begin
                emit           = adv;
                pulse.level    = ~r_cnt[0];
                pulse.duration = sym_head ? r_long : r_short;
                cell_ctl.shift = adv;
                if (adv) n_cnt = r_cnt + 1'b1;
            end
            PH_TAIL: begin
                emit           = adv;
                pulse.level    = 1'b1;
                pulse.duration = r_tail;
            end
            PH_GAP1: begin
                emit           = adv;
                in_ready       = adv;
                pulse.level    = 1'b0;
                pulse.duration = r_gap;
                pulse.last     = 1'b1;
            end
            default: ;
        endcase
        cell_ctl.load = in_xfer;
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= pulse;
        end
    end

    // symbol cell row
    mpfe_sym_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (cell_ctl),
        .i_frame    ({i_in_data.action, i_in_data.pager, i_in_data.station}),
        .i_polarity (r_pol),
        .o_head     (sym_head)
    );

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/mpfe_checker.sv =====
// port checker of the manchester pulse frame encoder, bound to the top level
module mpfe_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  mpfe_pkg::t_out_item             o_out_data
);
    import mpfe_pkg::*;

    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed before transfer");

    // the closing gap is a low pulse
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last |-> !o_out_data.level)
        else $error("closing pulse not low");

    // every high pulse is followed at once by a low pulse
    a_high_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.level
        |=> o_out_valid && !o_out_data.level)
        else $error("high pulse not followed by low pulse");

    // a new frame is only taken when the old one has nothing left but its last pulse
    a_take_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> i_out_ready || o_out_data.last)
        else $error("input taken while frame still in flight");

endmodule

bind manchester_pulse_frame_encoder_core mpfe_checker u_mpfe_checker (.*);

// ===== bench/tb_manchester_pulse_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// testbench of the manchester pulse frame encoder core: pulse trains checked against a predictor
module tb_manchester_pulse_frame_encoder_core;
    import mpfe_pkg::*;

    localparam int unsigned PULSES           = SYMBOLS + 3;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned RANDOM_PHASES    = 6;
    localparam int unsigned FRAMES_PER_PHASE = 55;
    localparam longint      TIMEOUT_NS       = 20_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_POLARITY + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    // receiver stall behaviour
    typedef enum logic [1:0] {
        RDY_FREE,
        RDY_LIGHT,
        RDY_SPARSE,
        RDY_HALF
    } t_ready_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // predictor copy of the registers
    logic [DUR_W-1:0] cfg_short = SHORT_RST;
    logic [DUR_W-1:0] cfg_long  = LONG_RST;
    logic [DUR_W-1:0] cfg_gap   = GAP_RST;
    logic [DUR_W-1:0] cfg_tail  = TAIL_RST;
    logic             cfg_pol   = POL_RST;

    t_out_item   frame_pulses[$];
    t_in_item    stim_q[$];
    int unsigned mismatches  = 0;
    int unsigned pulse_idx   = 0;
    int unsigned burst_left  = 0;
    int unsigned ready_left  = 0;
    t_ready_mode ready_mode  = RDY_FREE;

    manchester_pulse_frame_encoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // result side stalls: each mode holds for a random stretch
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            ready_left <= $urandom_range(40, 300);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            RDY_FREE:   i_out_ready <= 1'b1;
            RDY_LIGHT:  i_out_ready <= ($urandom_range(0, 3) != 0);
            RDY_SPARSE: i_out_ready <= (ready_left % 7 == 0);
            default:    i_out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    function automatic t_out_item make_pulse(input logic level, input logic [DUR_W-1:0] dur,
                                             input logic last);
        t_out_item p;
        p.level    = level;
        p.duration = dur;
        p.last     = last;
        return p;
    endfunction

    // gap, 48 manchester half-bits (high then low per bit), tail, closing gap
    function automatic void predict_pulses(input t_in_item it);
        logic [FRAME_BITS-1:0] bits;
        logic                  first_half;
        bits = {it.action, it.pager, it.station};
        frame_pulses.push_back(make_pulse(1'b0, cfg_gap, 1'b0));
        for (int i = 0; i < FRAME_BITS; i++) begin
            first_half = bits[i] ^ cfg_pol;
            frame_pulses.push_back(make_pulse(1'b1, first_half ? cfg_long : cfg_short, 1'b0));
            frame_pulses.push_back(make_pulse(1'b0, first_half ? cfg_short : cfg_long, 1'b0));
        end
        frame_pulses.push_back(make_pulse(1'b1, cfg_tail, 1'b0));
        frame_pulses.push_back(make_pulse(1'b0, cfg_gap, 1'b1));
    endfunction

    function automatic t_in_item make_item(input logic [STATION_W-1:0] station,
                                           input logic [PAGER_W-1:0] pager, input logic action);
        t_in_item it;
        it.station = station;
        it.pager   = pager;
        it.action  = action;
        return it;
    endfunction

    // mostly uniform fields, now and then all-zero or all-one fields
    function automatic t_in_item random_item();
        t_in_item it;
        if ($urandom_range(0, 9) == 0) begin
            it.station = ($urandom_range(0, 1) != 0) ? '1 : '0;
            it.pager   = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end else begin
            it.station = STATION_W'($urandom);
            it.pager   = PAGER_W'($urandom);
        end
        it.action = ($urandom_range(0, 1) != 0);
        return it;
    endfunction

    // durations lean towards zero, one and full scale
    function automatic logic [DUR_W-1:0] pick_duration();
        logic [DUR_W-1:0] d;
        case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = DUR_W'(1);
            2:       d = '1;
            default: d = DUR_W'($urandom_range(1, 65535));
        endcase
        return d;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at pulse %0d: %s expected %0d got %0d", pulse_idx, what, want, got);
    endtask

    // compare every result transfer with the oldest predicted pulse
    always @(posedge i_clk) begin : check_pulses
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_pulses.size() == 0) begin
                note_mismatch("unexpected pulse, duration", 0, o_out_data.duration);
            end else begin
                want = frame_pulses.pop_front();
                if (o_out_data.level !== want.level)
                    note_mismatch("level", want.level, o_out_data.level);
                if (o_out_data.duration !== want.duration)
                    note_mismatch("duration", want.duration, o_out_data.duration);
                if (o_out_data.last !== want.last)
                    note_mismatch("last", want.last, o_out_data.last);
            end
            pulse_idx <= (pulse_idx == PULSES - 1) ? 0 : pulse_idx + 1;
        end
    end

    // one register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_SHORT:    cfg_short = value;
            CFG_LONG:     cfg_long  = value;
            CFG_GAP:      cfg_gap   = value;
            CFG_TAIL:     cfg_tail  = value;
            CFG_POLARITY: cfg_pol   = value[0];
            default:      ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold one frame on the input until its transfer
    task automatic send_frame(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pulses(it);
    endtask

    // bursts of random length, random gaps between them
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 120);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic run_frames();
        while (stim_q.size() > 0) begin
            send_frame(stim_q.pop_front());
            if (stim_q.size() == 0)
                i_in_valid <= 1'b0;
            else
                pace_sender();
        end
    endtask

    // sender holds off until every predicted pulse has been seen
    task automatic wait_drained();
        while (frame_pulses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // reset values of the registers, field extremes and bit patterns
    task automatic test_default_frames();
        stim_q.push_back(make_item('0, '0, 1'b0));
        stim_q.push_back(make_item('1, '1, 1'b1));
        stim_q.push_back(make_item('1, '0, 1'b0));
        stim_q.push_back(make_item('0, '1, 1'b0));
        stim_q.push_back(make_item('0, '0, 1'b1));
        stim_q.push_back(make_item(13'h1555, 10'h2aa, 1'b0));
        stim_q.push_back(make_item(13'h0aaa, 10'h155, 1'b1));
        stim_q.push_back(make_item(13'h0001, 10'h200, 1'b0));
        run_frames();
        wait_drained();
    endtask

    // inverted coding; bits above the polarity bit must be ignored
    task automatic test_polarity();
        write_reg(CFG_POLARITY, 16'hffff);
        stim_q.push_back(make_item('1, '1, 1'b1));
        stim_q.push_back(make_item('0, '0, 1'b0));
        stim_q.push_back(make_item(13'h1555, 10'h2aa, 1'b1));
        run_frames();
        wait_drained();
        write_reg(CFG_POLARITY, 16'hfffe);
        stim_q.push_back(make_item(13'h0aaa, 10'h155, 1'b0));
        run_frames();
        wait_drained();
    endtask

    // zero, one and full-scale durations pass through as written
    task automatic test_duration_extremes();
        write_reg(CFG_SHORT, '0);
        write_reg(CFG_LONG, '1);
        write_reg(CFG_GAP, 16'd1);
        write_reg(CFG_TAIL, '0);
        stim_q.push_back(make_item(13'h1555, 10'h2aa, 1'b1));
        stim_q.push_back(make_item(13'h0f0f, 10'h0f0, 1'b0));
        run_frames();
        wait_drained();
        write_reg(CFG_SHORT, '1);
        write_reg(CFG_LONG, '0);
        write_reg(CFG_GAP, '1);
        write_reg(CFG_TAIL, '1);
        write_reg(CFG_POLARITY, 16'h0001);
        stim_q.push_back(make_item(13'h0aaa, 10'h155, 1'b0));
        stim_q.push_back(make_item(13'h1234, 10'h321, 1'b1));
        run_frames();
        wait_drained();
    endtask

    // writes to indexes past the last register change nothing
    task automatic test_unused_index();
        for (int i = CFG_FIRST_UNUSED; i <= CFG_LAST_UNUSED; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        stim_q.push_back(random_item());
        run_frames();
        wait_drained();
    endtask

    // random settings per phase, random frames in between
    task automatic test_random_frames();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_reg(CFG_SHORT, pick_duration());
            write_reg(CFG_LONG, pick_duration());
            write_reg(CFG_GAP, pick_duration());
            write_reg(CFG_TAIL, pick_duration());
            write_reg(CFG_POLARITY, CFG_DATA_W'($urandom));
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
                stim_q.push_back(random_item());
            run_frames();
            wait_drained();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_frames();
        test_polarity();
        test_duration_extremes();
        test_unused_index();
        test_random_frames();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hard stop if the pulse stream stalls
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
